@@ rtl/bos_pkg.sv @@
// Shared types, constants and value conversions for the bounded ordered sequence.
`default_nettype none
package bos_pkg;

	// Storage shape
	localparam int CAPACITY    = 256;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	// Fixed port widths
	localparam int ACT_W  = 3;
	localparam int POS_W  = 9;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int RIDX_W = 8;
	localparam int OCNT_W = 9;

	// Width used when comparing a position against the count
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT_AT     = 3'd0,
		ACT_SORTED_INSERT = 3'd1,
		ACT_ERASE_AT      = 3'd2,
		ACT_REMOVE_ALL    = 3'd3,
		ACT_READ          = 3'd4,
		ACT_WRITE         = 3'd5,
		ACT_FIND          = 3'd6
	} action_t;

	// Spare action code, answered as a no-op
	localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_POS   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		EOP_INSERT,
		EOP_ERASE,
		EOP_REMOVE,
		EOP_READ,
		EOP_WRITE,
		EOP_FIND
	} eng_op_t;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} top_state_t;

	typedef enum logic {
		E_IDLE,
		E_SCAN
	} eng_state_t;

	// Command handed to the scan engine
	typedef struct packed {
		eng_op_t                op;
		logic [CNT_W-1:0]       first;   // first address read
		logic [CNT_W-1:0]       last;    // one past the last address read
		logic                   placed;  // insert: new value already placed
		logic [IDX_W-1:0]       index;   // initial result index
		logic [VALUE_WIDTH-1:0] value;
	} eng_cmd_t;

	// Answer from the scan engine, valid with its done strobe
	typedef struct packed {
		logic [IDX_W-1:0]       index;
		logic                   found;
		logic [CNT_W-1:0]       kept;
		logic [VALUE_WIDTH-1:0] rd_value;
	} eng_rsp_t;

	// Sign-extend the port value, then reduce to the stored width
	function automatic logic [VALUE_WIDTH-1:0] to_entry(input logic [DATA_W-1:0] x);
		logic signed [DATA_W-1:0] s;
		logic signed [63:0]       t;
		s = x;
		t = 64'(s);
		return t[VALUE_WIDTH-1:0];
	endfunction

	// Sign-extend a stored entry, then reduce to the port width
	function automatic logic [DATA_W-1:0] from_entry(input logic [VALUE_WIDTH-1:0] e);
		logic signed [VALUE_WIDTH-1:0] s;
		logic signed [63:0]            t;
		s = e;
		t = 64'(s);
		return t[DATA_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/bos_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bos_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/bos_engine.sv @@
// Scan engine: streams the entry store, read-modify-write one address per cycle.
`default_nettype none
module bos_engine
	import bos_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start_i,
	input  wire eng_cmd_t cmd_i,
	output logic          done_o,
	output eng_rsp_t      rsp_o
);

	eng_state_t state_q, state_d;

	eng_op_t                op_q;
	logic [CNT_W-1:0]       rp_q;
	logic [CNT_W-1:0]       end_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic                   placed_q;
	logic [VALUE_WIDTH-1:0] carry_q;
	logic [IDX_W-1:0]       index_q;
	logic                   found_q;
	logic [CNT_W-1:0]       kept_q;
	logic [VALUE_WIDTH-1:0] rdv_q;
	logic                   v_s1;
	logic [IDX_W-1:0]       idx_s1;

	logic                   issue;
	logic                   fin;
	logic                   less;
	logic                   equal;
	logic                   we;
	logic [IDX_W-1:0]       waddr;
	logic [VALUE_WIDTH-1:0] wdata;
	logic [VALUE_WIDTH-1:0] rdata;

	assign issue = (state_q == E_SCAN) && (rp_q < end_q);
	assign fin   = (state_q == E_SCAN) && !(rp_q < end_q) && !v_s1;
	assign less  = $signed(val_q) < $signed(rdata);
	assign equal = (rdata == val_q);

	bos_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (issue),
		.raddr(rp_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done_o  = 1'b0;
		unique case (state_q)
			E_IDLE: begin
				if (start_i) begin
					state_d = E_SCAN;
				end
			end
			E_SCAN: begin
				if (fin) begin
					done_o  = 1'b1;
					state_d = E_IDLE;
				end
			end
			default: state_d = E_IDLE;
		endcase
	end

	// Write port: the address written is always at or below the one last read,
	// and every later read is above it, so no forwarding is needed.
	always_comb begin
		we    = 1'b0;
		waddr = idx_s1;
		wdata = rdata;
		case (op_q)
			EOP_INSERT: begin
				if (v_s1) begin
					if (placed_q) begin
						we    = 1'b1;
						wdata = carry_q;
					end else if (less) begin
						we    = 1'b1;
						wdata = val_q;
					end
				end else if (fin) begin
					we    = 1'b1;
					waddr = end_q[IDX_W-1:0];
					wdata = placed_q ? carry_q : val_q;
				end
			end
			EOP_ERASE: begin
				if (v_s1) begin
					we    = 1'b1;
					waddr = idx_s1 - IDX_W'(1);
				end
			end
			EOP_REMOVE: begin
				if (v_s1 && !equal) begin
					we    = 1'b1;
					waddr = kept_q[IDX_W-1:0];
				end
			end
			EOP_WRITE: begin
				if (fin) begin
					we    = 1'b1;
					waddr = end_q[IDX_W-1:0];
					wdata = val_q;
				end
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && start_i) begin
			op_q     <= cmd_i.op;
			rp_q     <= cmd_i.first;
			end_q    <= cmd_i.last;
			val_q    <= cmd_i.value;
			carry_q  <= cmd_i.value;
			placed_q <= cmd_i.placed;
			index_q  <= cmd_i.index;
			found_q  <= 1'b0;
			kept_q   <= '0;
		end else if (state_q == E_SCAN) begin
			idx_s1 <= rp_q[IDX_W-1:0];
			if (issue) begin
				rp_q <= rp_q + CNT_W'(1);
			end
			if (v_s1) begin
				case (op_q)
					EOP_INSERT: begin
						if (placed_q) begin
							carry_q <= rdata;
						end else if (less) begin
							placed_q <= 1'b1;
							index_q  <= idx_s1;
							carry_q  <= rdata;
						end
					end
					EOP_REMOVE: begin
						if (!equal) begin
							kept_q <= kept_q + CNT_W'(1);
						end
					end
					EOP_READ:   rdv_q <= rdata;
					EOP_FIND: begin
						if (!found_q && equal) begin
							found_q <= 1'b1;
							index_q <= idx_s1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// A sorted insert that met no larger entry lands at the tail
	always_comb begin
		rsp_o.index    = (op_q == EOP_INSERT && !placed_q) ? end_q[IDX_W-1:0] : index_q;
		rsp_o.found    = found_q;
		rsp_o.kept     = kept_q;
		rsp_o.rd_value = rdv_q;
	end

endmodule
`default_nettype wire

@@ rtl/bounded_ordered_sequence_top.sv @@
// Top level: request decode, range checks, item count and result registers.
// Timing: a rejected request or unused action gives done in the cycle after start;
//   the other actions run through the engine's scan and then a registered done.
// Throughput: one transaction at a time; busy is high while a scan runs and a
//   new start is taken in the cycle that done shows. The store's single read
//   port sets the figure: one entry read per cycle.
// Reset: arst_n clears the item count and control state; the store is not cleared.
`default_nettype none
module bounded_ordered_sequence_top
	import bos_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [ACT_W-1:0]  action,
	input  wire logic [POS_W-1:0]  position,
	input  wire logic [DATA_W-1:0] item_value,
	output logic                   done,
	output logic [STAT_W-1:0]      status,
	output logic [RIDX_W-1:0]      result_index,
	output logic [DATA_W-1:0]      read_value,
	output logic [OCNT_W-1:0]      removed_count,
	output logic [OCNT_W-1:0]      item_count
);

	top_state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	action_t           act_q;
	logic              done_q;
	status_t           status_q;
	logic [IDX_W-1:0]  index_q;
	logic [DATA_W-1:0] read_q;
	logic [OCNT_W-1:0] removed_q;

	logic             accept;
	logic             launch;
	status_t          imm_status;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic [CNT_W-1:0] pos_c;
	logic             bad_ins;
	logic             bad_pos;
	logic             full;
	eng_cmd_t         cmd;
	logic             eng_start;
	logic             eng_done;
	eng_rsp_t         rsp;

	assign busy   = (state_q == S_RUN);
	assign accept = start && !busy;

	assign pos_ext = CMP_W'(position);
	assign cnt_ext = CMP_W'(count_q);
	assign pos_c   = pos_ext[CNT_W-1:0];
	assign bad_ins = pos_ext > cnt_ext;
	assign bad_pos = pos_ext >= cnt_ext;
	assign full    = (count_q == CNT_W'(CAPACITY));

	// Decode: either answer at once (rejects, unused code) or hand to the engine
	always_comb begin
		launch     = 1'b0;
		imm_status = ST_OK;
		cmd.op     = EOP_FIND;
		cmd.first  = '0;
		cmd.last   = count_q;
		cmd.placed = 1'b0;
		cmd.index  = '0;
		cmd.value  = to_entry(item_value);
		unique case (action_t'(action))
			ACT_INSERT_AT: begin
				if (bad_ins) begin
					imm_status = ST_BAD_POS;
				end else if (full) begin
					imm_status = ST_FULL;
				end else begin
					launch     = 1'b1;
					cmd.op     = EOP_INSERT;
					cmd.first  = pos_c;
					cmd.placed = 1'b1;
					cmd.index  = pos_ext[IDX_W-1:0];
				end
			end
			ACT_SORTED_INSERT: begin
				if (full) begin
					imm_status = ST_FULL;
				end else begin
					launch = 1'b1;
					cmd.op = EOP_INSERT;
				end
			end
			ACT_ERASE_AT: begin
				if (bad_pos) begin
					imm_status = ST_BAD_POS;
				end else begin
					launch    = 1'b1;
					cmd.op    = EOP_ERASE;
					cmd.first = pos_c + CNT_W'(1);
				end
			end
			ACT_REMOVE_ALL: begin
				launch = 1'b1;
				cmd.op = EOP_REMOVE;
			end
			ACT_READ: begin
				if (bad_pos) begin
					imm_status = ST_BAD_POS;
				end else begin
					launch    = 1'b1;
					cmd.op    = EOP_READ;
					cmd.first = pos_c;
					cmd.last  = pos_c + CNT_W'(1);
				end
			end
			ACT_WRITE: begin
				if (bad_pos) begin
					imm_status = ST_BAD_POS;
				end else begin
					launch    = 1'b1;
					cmd.op    = EOP_WRITE;
					cmd.first = pos_c;
					cmd.last  = pos_c;
				end
			end
			ACT_FIND: begin
				launch = 1'b1;
				cmd.op = EOP_FIND;
			end
			default: imm_status = ST_OK;
		endcase
	end

	assign eng_start = accept && launch;

	bos_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start_i(eng_start),
		.cmd_i  (cmd),
		.done_o (eng_done),
		.rsp_o  (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (eng_start) begin
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				if (eng_done) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control: done strobe and item count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= (accept && !launch) || (busy && eng_done);
			if (busy && eng_done) begin
				case (act_q) inside
					ACT_INSERT_AT, ACT_SORTED_INSERT: count_q <= count_q + CNT_W'(1);
					ACT_ERASE_AT:                     count_q <= count_q - CNT_W'(1);
					ACT_REMOVE_ALL:                   count_q <= rsp.kept;
					default: ;
				endcase
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action_t'(action);
		end
		if (accept && !launch) begin
			status_q  <= imm_status;
			index_q   <= '0;
			read_q    <= '0;
			removed_q <= '0;
		end else if (busy && eng_done) begin
			status_q  <= ST_OK;
			index_q   <= '0;
			read_q    <= '0;
			removed_q <= '0;
			case (act_q) inside
				ACT_INSERT_AT, ACT_SORTED_INSERT: index_q <= rsp.index;
				ACT_REMOVE_ALL: removed_q <= OCNT_W'(count_q - rsp.kept);
				ACT_READ:       read_q    <= from_entry(rsp.rd_value);
				ACT_FIND: begin
					status_q <= rsp.found ? ST_OK : ST_NOT_FOUND;
					index_q  <= rsp.index;
				end
				default: ;
			endcase
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign result_index  = RIDX_W'(index_q);
	assign read_value    = read_q;
	assign removed_count = removed_q;
	assign item_count    = OCNT_W'(count_q);

endmodule
`default_nettype wire

@@ rtl/bos_checker.sv @@
// Port-level checker for the bounded ordered sequence, bound to the top level.
`default_nettype none
module bos_port_checker
	import bos_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic [ACT_W-1:0]  action,
	input wire logic              done,
	input wire logic [STAT_W-1:0] status,
	input wire logic [RIDX_W-1:0] result_index,
	input wire logic [OCNT_W-1:0] removed_count,
	input wire logic [OCNT_W-1:0] item_count
);

	// An accepted transaction either runs or is answered at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted transaction neither running nor answered");

	// A running transaction ends only with its result
	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// The unused action code answers at once with an ok status and nothing removed
	a_unused_code: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action == ACT_UNUSED |=>
			done && status == ST_OK && removed_count == '0 && result_index == '0)
		else $error("unused action code answered wrongly");

	// A full report only comes from a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> item_count == OCNT_W'(CAPACITY))
		else $error("list full reported below capacity");

endmodule

bind bounded_ordered_sequence_top bos_port_checker u_bos_checker (.*);
`default_nettype wire
